// ----- src/sha512_pkg.sv -----
// Package with types, constants and a rotate helper for the SHA-512/384 engine.
package sha512_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        is_last;
    } sha_in_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // One queued word for the back end: a block word and block control.
    typedef struct packed {
        logic [63:0] word;
        logic        first;      // first word of a message: load the IV
        logic        final_blk;  // this word closes the final block
        logic        mode;       // digest mode latched at message start/end
    } sha_cmd_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_PAD,
        FE_LEN_HI,
        FE_LEN_LO
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_FILL,
        BE_ROUND,
        BE_ADD,
        BE_OUT
    } be_state_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;

    localparam logic [63:0] PAD_WORD = 64'h8000000000000000;

    localparam logic [63:0] ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] IV_512 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] IV_384 [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ----- src/sha512_front.sv -----
// Front end: takes message words, tracks the length and emits padded block words.
module sha512_front
    import sha512_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mode,
    input  logic     in_valid,
    output logic     in_stall,
    input  sha_in_t  in_data,
    output logic     cmd_valid,
    input  logic     cmd_stall,
    output sha_cmd_t cmd
);

    fe_state_t   state_reg, state_next;
    logic [63:0] total_reg, total_next;
    logic [3:0]  pos_reg, pos_next;
    logic        started_reg, started_next;
    logic        mode_reg, mode_next;
    logic        padmark_reg, padmark_next;

    logic [3:0]  cnt;
    logic [63:0] keep;
    logic [63:0] total_add;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= FE_IDLE;
            total_reg   <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
            mode_reg    <= 1'b0;
            padmark_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
            mode_reg    <= mode_next;
            padmark_reg <= padmark_next;
        end
    end

    always_comb begin
        cnt = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
        if (!in_data.is_last) begin
            cnt = 4'd8;
        end
        keep = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt, 3'b000});
        total_add = (started_reg ? total_reg : 64'd0) + {60'd0, cnt};
    end

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        mode_next    = mode_reg;
        padmark_next = padmark_reg;
        in_stall     = 1'b1;
        cmd_valid    = 1'b0;
        cmd          = '0;
        cmd.mode     = mode_reg;
        unique case (state_reg)
            FE_IDLE: begin
                in_stall  = cmd_stall;
                cmd_valid = in_valid;
                cmd.first = !started_reg;
                cmd.mode  = started_reg ? mode_reg : mode;
                if (!in_data.is_last || cnt == 4'd8) begin
                    cmd.word = in_data.data_word;
                end else begin
                    cmd.word = (in_data.data_word & keep) | (PAD_WORD >> {cnt, 3'b000});
                end
                if (in_valid && !cmd_stall) begin
                    total_next   = total_add;
                    pos_next     = (started_reg ? pos_reg : 4'd0) + 4'd1;
                    started_next = 1'b1;
                    if (!started_reg) begin
                        mode_next = mode;
                    end
                    if (in_data.is_last) begin
                        // The digest length follows the mode seen with the last word.
                        mode_next = mode;
                        if (cnt == 4'd8) begin
                            padmark_next = 1'b1;
                            state_next   = FE_PAD;
                        end else begin
                            state_next = (pos_next == 4'd15) ? FE_PAD
                                       : ((pos_next == 4'd14) ? FE_LEN_HI : FE_PAD);
                        end
                    end
                end
            end
            FE_PAD: begin
                // The first pad beat carries the marker when the last word was full;
                // every other pad beat is zero.
                cmd_valid = 1'b1;
                cmd.word  = padmark_reg ? PAD_WORD : '0;
                if (!cmd_stall) begin
                    padmark_next = 1'b0;
                    pos_next     = pos_reg + 4'd1;
                    if (pos_next == 4'd14) begin
                        state_next = FE_LEN_HI;
                    end
                end
            end
            FE_LEN_HI: begin
                cmd_valid = 1'b1;
                cmd.word  = '0;
                if (!cmd_stall) begin
                    pos_next   = pos_reg + 4'd1;
                    state_next = FE_LEN_LO;
                end
            end
            FE_LEN_LO: begin
                cmd_valid     = 1'b1;
                cmd.word      = {total_reg[60:0], 3'b000};
                cmd.final_blk = 1'b1;
                if (!cmd_stall) begin
                    pos_next     = 4'd0;
                    started_next = 1'b0;
                    state_next   = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

endmodule

// ----- src/sha512_queue.sv -----
// Short queue of block words between the front and back ends.
module sha512_queue
    import sha512_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_stall,
    input  sha_cmd_t wr_data,
    output logic     rd_valid,
    input  logic     rd_stall,
    output sha_cmd_t rd_data
);

    sha_cmd_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic wr_en, rd_en;

    assign wr_stall = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_valid && !rd_stall;

    always_comb begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + (QUEUE_AW+1)'(1);
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr_en) begin
                wp_reg <= wp_reg + QUEUE_AW'(1);
            end
            if (rd_en) begin
                rp_reg <= rp_reg + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
    end

endmodule

// ----- src/sha512_back.sv -----
// Back end: gathers block words, runs 80 rounds and delivers digest words.
module sha512_back
    import sha512_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  sha_cmd_t cmd,
    output logic     out_valid,
    input  logic     out_stall,
    output sha_out_t out_data
);

    be_state_t   state_reg, state_next;
    logic [63:0] w_reg [BLOCK_WORDS];
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [3:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic        final_reg;
    logic        mode_reg;
    logic [2:0]  oidx_reg;

    logic [63:0] x2, x15, s0, s1, w_new, wt, t1, t2;
    logic [63:0] a, b, c, d, e, f, g, h;
    logic [3:0]  ri;
    logic        take;

    assign ri = rnd_reg[3:0];
    assign {a, b, c, d} = {v_reg[0], v_reg[1], v_reg[2], v_reg[3]};
    assign {e, f, g, h} = {v_reg[4], v_reg[5], v_reg[6], v_reg[7]};

    always_comb begin
        x2    = w_reg[ri - 4'd2];
        x15   = w_reg[ri - 4'd15];
        s1    = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
        s0    = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
        w_new = w_reg[ri] + s1 + w_reg[ri - 4'd7] + s0;
        wt    = (rnd_reg >= 7'd16) ? w_new : w_reg[ri];
        t1    = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + (g ^ (e & (f ^ g)))
              + ROUND_K[rnd_reg] + wt;
        t2    = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (c & (a ^ b)));
    end

    assign cmd_stall = (state_reg != BE_FILL);
    assign take      = cmd_valid && (state_reg == BE_FILL);
    assign out_valid = (state_reg == BE_OUT);
    assign out_data.digest_word = h_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = mode_reg ? (oidx_reg == 3'd5) : (oidx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BE_FILL:  if (take && pos_reg == 4'd15) state_next = BE_ROUND;
            BE_ROUND: if (rnd_reg == 7'(ROUNDS - 1)) state_next = BE_ADD;
            BE_ADD:   state_next = final_reg ? BE_OUT : BE_FILL;
            BE_OUT:   if (!out_stall && out_data.last_word) state_next = BE_FILL;
            default:  state_next = BE_FILL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= BE_FILL;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            final_reg <= 1'b0;
            mode_reg  <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= IV_512[i];
                v_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                BE_FILL: begin
                    if (take) begin
                        pos_reg <= pos_reg + 4'd1;
                        if (cmd.first) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= cmd.mode ? IV_384[i] : IV_512[i];
                            end
                        end
                        if (pos_reg == 4'd15) begin
                            final_reg <= cmd.final_blk;
                            mode_reg  <= cmd.mode;
                            rnd_reg   <= '0;
                            for (int i = 0; i < 8; i++) begin
                                v_reg[i] <= cmd.first ? (cmd.mode ? IV_384[i] : IV_512[i])
                                                      : h_reg[i];
                            end
                        end
                    end
                end
                BE_ROUND: begin
                    rnd_reg  <= rnd_reg + 7'd1;
                    v_reg[0] <= t1 + t2;
                    v_reg[1] <= a;
                    v_reg[2] <= b;
                    v_reg[3] <= c;
                    v_reg[4] <= d + t1;
                    v_reg[5] <= e;
                    v_reg[6] <= f;
                    v_reg[7] <= g;
                end
                BE_ADD: begin
                    rnd_reg  <= '0;
                    oidx_reg <= '0;
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                BE_OUT: begin
                    if (!out_stall) begin
                        oidx_reg <= oidx_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Message schedule words live in a 16-entry rolling window.
    always_ff @(posedge clk) begin
        if (take) begin
            w_reg[pos_reg] <= cmd.word;
        end else if (state_reg == BE_ROUND && rnd_reg >= 7'd16) begin
            w_reg[ri] <= w_new;
        end
    end

endmodule

// ----- src/sha512_sha384_hash_engine_core.sv -----
// Top level of the SHA-512/SHA-384 engine: config register, front end, queue, back end.
// After the last word the front end emits pad words and the two length words, which may
// spill into a second block; the back end runs the rounds and chaining add per block and
// then digest words leave one per cycle while out_stall is low, 8 or 6 for SHA-384.
// In fill state the back end takes one block word per cycle while the queue has one; it
// then runs the 80 rounds (one round a cycle) and takes no word in its round, add or out states.
// Reset clears all control state; the chaining value resets to the SHA-512 initial values.
module sha512_sha384_hash_engine_core
    import sha512_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data,
    input  logic     in_valid,
    output logic     in_stall,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output sha_out_t out_data
);

    // The mode register is written directly; it always accepts a beat.
    logic     mode_reg;
    logic     q_wr_valid, q_wr_stall, q_rd_valid, q_rd_stall;
    sha_cmd_t q_wr_data, q_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // Front end pads the message and emits exactly sixteen words per block.
    sha512_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (q_wr_valid),
        .cmd_stall (q_wr_stall),
        .cmd       (q_wr_data)
    );

    // The queue lets the front end keep padding while the rounds run.
    sha512_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_stall (q_wr_stall),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_stall (q_rd_stall),
        .rd_data  (q_rd_data)
    );

    // Back end compresses blocks and presents the digest one beat at a time.
    sha512_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_rd_valid),
        .cmd_stall (q_rd_stall),
        .cmd       (q_rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
